@@ sv/wprs_pkg.sv @@
// Shared types and register codes for the windowed pulse/ramp stimulus block.
`timescale 1ns / 1ps

package wprs_pkg;

	localparam int AMP_W    = 32;
	localparam int STEP_W   = 32;
	localparam int TICKS_W  = 16;
	localparam int PERIOD_W = 17;
	localparam int CNT_W    = 5;
	localparam int SLOT_W   = 4;
	localparam int CIDX_W   = 3;
	localparam int CDATA_W  = 32;
	localparam int IN_DATA_W  = 104;
	localparam int OUT_DATA_W = 40;

	typedef enum logic [CIDX_W-1:0] {
		REG_MODE         = 3'd0,
		REG_AMP_INIT     = 3'd1,
		REG_AMP_STEP     = 3'd2,
		REG_PULSE_WIDTH  = 3'd3,
		REG_PULSE_PERIOD = 3'd4,
		REG_INTERVAL_CNT = 3'd5
	} reg_idx_t;

	typedef enum logic {
		REQ_TICK = 1'b0,
		REQ_LOAD = 1'b1
	} req_type_t;

	typedef enum logic {
		MODE_PULSE  = 1'b0,
		MODE_LINEAR = 1'b1
	} mode_t;

	typedef struct packed {
		mode_t                     mode;
		logic signed [AMP_W-1:0]   amp_init;
		logic signed [AMP_W-1:0]   amp_step;
		logic [TICKS_W-1:0]        pulse_width_ticks;
		logic [TICKS_W-1:0]        pulse_period_ticks;
		logic [CNT_W-1:0]          interval_count;
	} cfg_t;

	typedef struct packed {
		req_type_t          req_type;
		logic [STEP_W-1:0]  time_step;
		logic [SLOT_W-1:0]  interval_slot;
		logic [STEP_W-1:0]  interval_start;
		logic [STEP_W-1:0]  interval_stop;
	} item_t;

	typedef struct packed {
		logic [STEP_W-1:0] start;
		logic [STEP_W-1:0] stop;
	} entry_t;

	typedef struct packed {
		logic                    emit;
		logic signed [AMP_W-1:0] amplitude;
		logic                    in_window;
		logic                    finished;
	} result_t;

endpackage

@@ sv/wprs_cfg.sv @@
// Configuration register file with its write channel.
`timescale 1ns / 1ps

module wprs_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [wprs_pkg::CIDX_W-1:0]  cfg_index,
	input  logic [wprs_pkg::CDATA_W-1:0] cfg_data,
	output wprs_pkg::cfg_t               cfg
);
	import wprs_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode               <= MODE_PULSE;
			cfg_q.amp_init           <= '0;
			cfg_q.amp_step           <= '0;
			cfg_q.pulse_width_ticks  <= TICKS_W'(1);
			cfg_q.pulse_period_ticks <= TICKS_W'(1);
			cfg_q.interval_count     <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MODE:         cfg_q.mode <= mode_t'(cfg_data[0]);
				REG_AMP_INIT:     cfg_q.amp_init <= cfg_data[AMP_W-1:0];
				REG_AMP_STEP:     cfg_q.amp_step <= cfg_data[AMP_W-1:0];
				REG_PULSE_WIDTH:  cfg_q.pulse_width_ticks <= cfg_data[TICKS_W-1:0];
				REG_PULSE_PERIOD: cfg_q.pulse_period_ticks <= cfg_data[TICKS_W-1:0];
				REG_INTERVAL_CNT: cfg_q.interval_count <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

@@ sv/wprs_table.sv @@
// Interval table: start/stop pairs, one write port, one read port.
`timescale 1ns / 1ps

module wprs_table #(
	parameter int MAX_INTERVALS = 16
) (
	input  logic                        clk,
	input  logic                        wr_en,
	input  logic [wprs_pkg::SLOT_W-1:0] wr_slot,
	input  wprs_pkg::entry_t            wr_entry,
	input  logic [wprs_pkg::CNT_W-1:0]  rd_idx,
	output wprs_pkg::entry_t            rd_entry
);
	import wprs_pkg::*;

	// A 4-bit slot reaches at most sixteen entries.
	localparam int TBL_DEPTH = (MAX_INTERVALS < 16) ? MAX_INTERVALS : 16;
	localparam int IDX_W     = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;

	entry_t tbl_q [TBL_DEPTH];
	logic   slot_ok;

	assign slot_ok = 32'(wr_slot) < TBL_DEPTH;

	always_ff @(posedge clk) begin
		if (wr_en && slot_ok) begin
			tbl_q[wr_slot[IDX_W-1:0]] <= wr_entry;
		end
	end

	assign rd_entry = tbl_q[rd_idx[IDX_W-1:0]];

endmodule

@@ sv/wprs_core.sv @@
// Window tracking, pulse counters and amplitude ramp for one item per cycle while commit is high.
`timescale 1ns / 1ps

module wprs_core #(
	parameter int MAX_INTERVALS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       commit,
	input  wprs_pkg::item_t            item,
	input  wprs_pkg::cfg_t             cfg,
	input  wprs_pkg::entry_t           entry,
	output logic [wprs_pkg::CNT_W-1:0] rd_idx,
	output wprs_pkg::result_t          result
);
	import wprs_pkg::*;

	localparam int CNT_CAP_I = (MAX_INTERVALS > 31) ? 31 : MAX_INTERVALS;
	localparam logic [CNT_W-1:0] CNT_CAP = CNT_W'(CNT_CAP_I);

	function automatic logic signed [AMP_W-1:0] sat_add(
		input logic signed [AMP_W-1:0] a,
		input logic signed [AMP_W-1:0] b
	);
		logic signed [AMP_W:0] s;
		logic signed [AMP_W-1:0] r;
		s = {a[AMP_W-1], a} + {b[AMP_W-1], b};
		if (s[AMP_W] != s[AMP_W-1]) begin
			r = s[AMP_W] ? {1'b1, {(AMP_W-1){1'b0}}} : {1'b0, {(AMP_W-1){1'b1}}};
		end else begin
			r = s[AMP_W-1:0];
		end
		return r;
	endfunction

	logic [CNT_W-1:0]        idx_q, idx_n;
	logic signed [AMP_W-1:0] amp_q, amp_n;
	logic                    pulse_q, pulse_n;
	logic [TICKS_W-1:0]      width_q, width_n;
	logic [PERIOD_W-1:0]     period_q, period_n;
	logic                    done_q, done_n;

	logic [CNT_W-1:0]        count;
	logic [CNT_W-1:0]        idx_inc;
	logic                    hit;
	logic signed [AMP_W-1:0] amp_ramp;

	assign rd_idx   = idx_q;
	assign count    = (cfg.interval_count > CNT_CAP) ? CNT_CAP : cfg.interval_count;
	assign idx_inc  = idx_q + CNT_W'(1);
	assign amp_ramp = sat_add(amp_q, cfg.amp_step);
	assign hit      = (idx_q < count) && (item.time_step >= entry.start)
		&& (item.time_step <= entry.stop);

	always_comb begin
		idx_n    = idx_q;
		amp_n    = amp_q;
		pulse_n  = pulse_q;
		width_n  = width_q;
		period_n = period_q;
		done_n   = done_q;
		result   = '0;

		if (item.req_type == REQ_LOAD) begin
			// Loading slot 0 rearms the generator.
			if (item.interval_slot == '0) begin
				idx_n    = '0;
				done_n   = 1'b0;
				amp_n    = cfg.amp_init;
				pulse_n  = 1'b1;
				width_n  = cfg.pulse_width_ticks;
				period_n = PERIOD_W'(cfg.pulse_period_ticks);
			end
		end else if (!done_q && hit) begin
			result.in_window = 1'b1;
			if (cfg.mode == MODE_LINEAR) begin
				result.emit      = 1'b1;
				result.amplitude = amp_q;
				amp_n            = amp_ramp;
			end else begin
				if (pulse_q) begin
					if (amp_q != '0) begin
						result.emit      = 1'b1;
						result.amplitude = amp_q;
					end
					amp_n   = amp_ramp;
					width_n = width_q - TICKS_W'(1);
					if (width_n == '0) begin
						pulse_n = 1'b0;
					end
				end
				// Period start: restart pulse and amplitude.
				if (period_q <= PERIOD_W'(1)) begin
					pulse_n  = 1'b1;
					amp_n    = cfg.amp_init;
					width_n  = cfg.pulse_width_ticks;
					period_n = PERIOD_W'(cfg.pulse_period_ticks);
				end else begin
					period_n = period_q - PERIOD_W'(1);
				end
			end
			if (item.time_step == entry.stop) begin
				idx_n = idx_inc;
				if (idx_inc >= count) begin
					done_n = 1'b1;
				end else begin
					width_n  = cfg.pulse_width_ticks;
					period_n = PERIOD_W'(cfg.pulse_period_ticks);
				end
			end
		end
		result.finished = done_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			amp_q    <= '0;
			pulse_q  <= 1'b1;
			width_q  <= TICKS_W'(1);
			period_q <= PERIOD_W'(1);
			done_q   <= 1'b0;
		end else if (commit) begin
			idx_q    <= idx_n;
			amp_q    <= amp_n;
			pulse_q  <= pulse_n;
			width_q  <= width_n;
			period_q <= period_n;
			done_q   <= done_n;
		end
	end

endmodule

@@ sv/windowed_pulse_ramp_stimulus_top.sv @@
// Top level: input register, stimulus core, interval table and result register.
// An item passes the input register, then the result register, where m_tvalid rises.
// Throughput: one item per cycle unless stalled; core state updates as items move to the result.
// The result register and input register hold while m_tready is low; input keeps flowing
// as long as the result register is free or being drained.
// Reset: arst_n clears control state and config to defaults; the interval table has no reset.
`timescale 1ns / 1ps

module windowed_pulse_ramp_stimulus_top #(
	parameter int MAX_INTERVALS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// time_step[31:0], interval_slot[35:32], interval_start[67:36], interval_stop[99:68]
	input  logic [wprs_pkg::IN_DATA_W-1:0]  s_tdata,
	// req_type[0]
	input  logic                            s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// emit[0], amplitude[32:1], in_window[33], finished[34]
	output logic [wprs_pkg::OUT_DATA_W-1:0] m_tdata,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [wprs_pkg::CIDX_W-1:0]     cfg_index,
	input  logic [wprs_pkg::CDATA_W-1:0]    cfg_data
);
	import wprs_pkg::*;

	cfg_t             cfg;
	item_t            item_in;
	item_t            item_s1;
	logic             valid_s1;
	result_t          result_n;
	result_t          result_q;
	logic             out_valid_q;
	logic             advance;
	entry_t           entry;
	entry_t           wr_entry;
	logic [CNT_W-1:0] rd_idx;

	assign item_in.req_type       = req_type_t'(s_tuser);
	assign item_in.time_step      = s_tdata[31:0];
	assign item_in.interval_slot  = s_tdata[35:32];
	assign item_in.interval_start = s_tdata[67:36];
	assign item_in.interval_stop  = s_tdata[99:68];

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	assign wr_entry.start = item_s1.interval_start;
	assign wr_entry.stop  = item_s1.interval_stop;

	wprs_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	wprs_table #(
		.MAX_INTERVALS (MAX_INTERVALS)
	) u_table (
		.clk      (clk),
		.wr_en    (advance && (item_s1.req_type == REQ_LOAD)),
		.wr_slot  (item_s1.interval_slot),
		.wr_entry (wr_entry),
		.rd_idx   (rd_idx),
		.rd_entry (entry)
	);

	wprs_core #(
		.MAX_INTERVALS (MAX_INTERVALS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.commit (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.entry  (entry),
		.rd_idx (rd_idx),
		.result (result_n)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			valid_s1    <= (s_tvalid && s_tready) || (valid_s1 && !advance);
			out_valid_q <= advance || (out_valid_q && !m_tready);
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= item_in;
		end
		if (advance) begin
			result_q <= result_n;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {(OUT_DATA_W - AMP_W - 3)'(0), result_q.finished, result_q.in_window,
		result_q.amplitude, result_q.emit};

	// A committed item always lands in the result register.
	a_advance_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("committed item did not reach result register");

	// A stalled item in the input register is not dropped.
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1)
		else $error("input register lost a stalled item");

	// Emission only happens inside a window, with zero amplitude otherwise.
	a_emit_window: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && result_q.emit |-> result_q.in_window)
		else $error("emit outside window");

	a_quiet_amp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !result_q.emit |-> result_q.amplitude == '0)
		else $error("nonzero amplitude without emit");

	// Load items never report a window hit.
	a_load_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.req_type == REQ_LOAD |=> !result_q.in_window && !result_q.emit)
		else $error("load item reported stimulus");

endmodule
